// ----- sv/ctia_pkg.sv -----
package ctia_pkg;

    // Default configuration of the table
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF       = 16;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int CENTER_W   = 13;
    localparam int TIME_W     = 32;
    localparam int TRACK_ID_W = 16;
    localparam int RADIUS_W   = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [RADIUS_W-1:0] MATCH_RADIUS_RST    = 12'd150;
    localparam logic [RADIUS_W-1:0] FALLBACK_RADIUS_RST = 12'd150;
    localparam logic [TIME_W-1:0]   MAX_GAP_TIME_RST    = 32'd1000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_RADIUS    = 2'd0,
        CFG_FALLBACK_RADIUS = 2'd1,
        CFG_MAX_GAP_TIME    = 2'd2
    } cfg_index_t;

    // Input item
    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  box_x;
        logic [COORD_W-1:0]  box_y;
        logic [COORD_W-1:0]  box_w;
        logic [COORD_W-1:0]  box_h;
        logic [CENTER_W-1:0] last_cx;
        logic [CENTER_W-1:0] last_cy;
        logic [TIME_W-1:0]   elapsed_ms;
    } in_t;

    // Result item
    typedef struct packed {
        logic [COORD_W-1:0]    out_x;
        logic [COORD_W-1:0]    out_y;
        logic [COORD_W-1:0]    out_w;
        logic [COORD_W-1:0]    out_h;
        logic [TRACK_ID_W-1:0] track_id;
        logic                  is_new;
        logic                  table_full;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch a detection, clear scan results
        logic prune;      // end of frame: drop unhit entries
        logic scan_step;  // read the next table entry
        logic commit;     // apply the decision, load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // current read is the last table entry
        logic pipe_busy;  // compare pipeline still holds entries
        logic out_free;   // result register can take a new item
    } status_t;

endpackage

// ----- sv/ctia_ram.sv -----
module ctia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ctia_ctrl.sv -----
module ctia_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               in_func,
    output logic               s_ready,
    output ctia_pkg::cmd_t     cmd,
    input  ctia_pkg::status_t  stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;
    logic   accept;

    assign s_ready = s_ready_reg;
    assign accept  = s_valid && s_ready_reg;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        s_ready_next  = s_ready_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_func) begin
                        cmd.prune = 1'b1;
                    end else begin
                        cmd.load     = 1'b1;
                        state_next   = ST_SCAN;
                        s_ready_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.commit   = 1'b1;
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

endmodule

// ----- sv/ctia_dp.sv -----
module ctia_dp #(
    parameter int TABLE_ENTRIES = ctia_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = ctia_pkg::ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ctia_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ctia_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    input  logic [ctia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctia_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  ctia_pkg::cmd_t                    cmd,
    output ctia_pkg::status_t                 stat
);

    localparam int N       = TABLE_ENTRIES;
    localparam int IDX_W   = (N > 1) ? $clog2(N) : 1;
    localparam int CW      = ctia_pkg::CENTER_W;
    localparam int XW      = ctia_pkg::COORD_W;
    localparam int RW      = ctia_pkg::RADIUS_W;
    localparam int TW      = ctia_pkg::TIME_W;
    localparam int TIDW    = ctia_pkg::TRACK_ID_W;
    localparam int SQW     = 2 * CW;
    localparam int DW      = SQW + 1;
    localparam int R2W     = 2 * RW;
    localparam int ENTRY_W = ID_BITS + 2 * CW;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [RW-1:0] match_r_reg;
    logic [RW-1:0] fb_r_reg;
    logic [TW-1:0] gap_reg;
    logic [R2W-1:0] r2_reg;
    logic [R2W-1:0] f2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_r_reg <= ctia_pkg::MATCH_RADIUS_RST;
            fb_r_reg    <= ctia_pkg::FALLBACK_RADIUS_RST;
            gap_reg     <= ctia_pkg::MAX_GAP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ctia_pkg::CFG_MATCH_RADIUS:    match_r_reg <= cfg_data[RW-1:0];
                ctia_pkg::CFG_FALLBACK_RADIUS: fb_r_reg    <= cfg_data[RW-1:0];
                ctia_pkg::CFG_MAX_GAP_TIME:    gap_reg     <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Squared radii, refreshed every cycle from stable registers
    always_ff @(posedge aclk) begin
        r2_reg <= R2W'(match_r_reg) * R2W'(match_r_reg);
        f2_reg <= R2W'(fb_r_reg) * R2W'(fb_r_reg);
    end

    // Latched detection and its center
    logic [XW-1:0] bx_reg, by_reg, bw_reg, bh_reg;
    logic [CW-1:0] cx_reg, cy_reg, lx_reg, ly_reg;
    logic [TW-1:0] el_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bx_reg <= s_data.box_x;
            by_reg <= s_data.box_y;
            bw_reg <= s_data.box_w;
            bh_reg <= s_data.box_h;
            cx_reg <= CW'(s_data.box_x) + CW'(s_data.box_w >> 1);
            cy_reg <= CW'(s_data.box_y) + CW'(s_data.box_h >> 1);
            lx_reg <= s_data.last_cx;
            ly_reg <= s_data.last_cy;
            el_reg <= s_data.elapsed_ms;
        end
    end

    // Fallback distance squares
    logic [SQW-1:0] fbx_sq_reg, fby_sq_reg;
    logic [CW-1:0]  fdx, fdy;

    assign fdx = abs_diff(cx_reg, lx_reg);
    assign fdy = abs_diff(cy_reg, ly_reg);

    always_ff @(posedge aclk) begin
        fbx_sq_reg <= SQW'(fdx) * SQW'(fdx);
        fby_sq_reg <= SQW'(fdy) * SQW'(fdy);
    end

    // Table state
    logic [N-1:0]       valid_reg;
    logic [N-1:0]       hit_reg;
    logic [ID_BITS-1:0] next_id_reg;
    logic [ID_BITS-1:0] saved_id_reg;

    // Scan address counter and entry memory
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [ENTRY_W-1:0] rd_data;
    logic               ram_we;
    logic [IDX_W-1:0]   wr_slot;
    logic [ID_BITS-1:0] sel_id;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            scan_cnt_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    ctia_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (N)
    ) u_entry_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (wr_slot),
        .wr_data ({sel_id, cx_reg, cy_reg}),
        .rd_en   (cmd.scan_step),
        .rd_addr (scan_cnt_reg),
        .rd_data (rd_data)
    );

    // Pipeline stage 1: read data arrives, form squares
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ID_BITS-1:0] e_id;
    logic [CW-1:0]      e_cx, e_cy, edx, edy;

    assign e_id = rd_data[ENTRY_W-1 -: ID_BITS];
    assign e_cx = rd_data[2*CW-1 -: CW];
    assign e_cy = rd_data[CW-1:0];
    assign edx  = abs_diff(cx_reg, e_cx);
    assign edy  = abs_diff(cy_reg, e_cy);

    logic               sq_vld_reg;
    logic               sq_ev_reg;
    logic [IDX_W-1:0]   sq_idx_reg;
    logic [ID_BITS-1:0] sq_id_reg;
    logic [SQW-1:0]     sq_x_reg, sq_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_step;
            sq_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_cnt_reg;
        sq_ev_reg  <= valid_reg[rd_idx_reg];
        sq_idx_reg <= rd_idx_reg;
        sq_id_reg  <= e_id;
        sq_x_reg   <= SQW'(edx) * SQW'(edx);
        sq_y_reg   <= SQW'(edy) * SQW'(edy);
    end

    // Pipeline stage 2: compare and keep the best match, a duplicate ID and a free slot
    logic [DW-1:0]      sum_sq;
    logic               is_match;
    logic               best_found_reg, any_valid_reg, dup_found_reg, free_found_reg;
    logic [ID_BITS-1:0] best_id_reg;
    logic [IDX_W-1:0]   best_slot_reg, dup_slot_reg, free_slot_reg;

    assign sum_sq   = DW'(sq_x_reg) + DW'(sq_y_reg);
    assign is_match = sum_sq < DW'(r2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
            any_valid_reg  <= 1'b0;
            dup_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            best_found_reg <= 1'b0;
            any_valid_reg  <= 1'b0;
            dup_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (sq_vld_reg) begin
            if (sq_ev_reg) begin
                any_valid_reg <= 1'b1;
                if (is_match && (!best_found_reg || sq_id_reg < best_id_reg)) begin
                    best_found_reg <= 1'b1;
                end
                if (sq_id_reg == next_id_reg) begin
                    dup_found_reg <= 1'b1;
                end
            end else begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_vld_reg) begin
            if (sq_ev_reg) begin
                // strict compare: equal IDs keep the lower slot
                if (is_match && (!best_found_reg || sq_id_reg < best_id_reg)) begin
                    best_id_reg   <= sq_id_reg;
                    best_slot_reg <= sq_idx_reg;
                end
                if (!dup_found_reg && sq_id_reg == next_id_reg) begin
                    dup_slot_reg <= sq_idx_reg;
                end
            end else if (!free_found_reg) begin
                free_slot_reg <= sq_idx_reg;
            end
        end
    end

    // Decision: match, fallback reuse, or fresh ID
    logic [DW-1:0] fb_dist;
    logic          fb_ok;
    logic          sel_new, sel_full, sel_store;

    assign fb_dist = DW'(fbx_sq_reg) + DW'(fby_sq_reg);
    assign fb_ok   = !any_valid_reg && (fb_dist < DW'(f2_reg)) && (el_reg < gap_reg);

    always_comb begin
        sel_id    = next_id_reg;
        sel_new   = 1'b1;
        sel_full  = 1'b0;
        wr_slot   = free_slot_reg;
        sel_store = free_found_reg;
        if (best_found_reg) begin
            sel_id    = best_id_reg;
            sel_new   = 1'b0;
            wr_slot   = best_slot_reg;
            sel_store = 1'b1;
        end else if (fb_ok) begin
            sel_id  = saved_id_reg;
            sel_new = 1'b0;
        end else if (dup_found_reg) begin
            wr_slot   = dup_slot_reg;
            sel_store = 1'b1;
        end else begin
            sel_full = !free_found_reg;
        end
    end

    assign ram_we = cmd.commit && sel_store;

    // Valid and hit bits, ID counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            hit_reg      <= '0;
            next_id_reg  <= '0;
            saved_id_reg <= '0;
        end else if (cmd.prune) begin
            valid_reg <= valid_reg & hit_reg;
            hit_reg   <= '0;
        end else if (cmd.commit) begin
            if (sel_store) begin
                valid_reg[wr_slot] <= 1'b1;
                hit_reg[wr_slot]   <= 1'b1;
            end
            if (best_found_reg) begin
                saved_id_reg <= best_id_reg;
            end else if (!fb_ok) begin
                next_id_reg  <= next_id_reg + 1'b1;
                saved_id_reg <= next_id_reg + 1'b1;
            end
        end
    end

    // Result register
    logic           m_valid_reg;
    ctia_pkg::out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg.out_x      <= bx_reg;
            m_data_reg.out_y      <= by_reg;
            m_data_reg.out_w      <= bw_reg;
            m_data_reg.out_h      <= bh_reg;
            m_data_reg.track_id   <= TIDW'(sel_id);
            m_data_reg.is_new     <= sel_new;
            m_data_reg.table_full <= sel_full;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status to the controller
    assign stat.scan_last = (scan_cnt_reg == IDX_W'(N - 1));
    assign stat.pipe_busy = rd_vld_reg || sq_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

// ----- sv/centroid_track_id_assigner.sv -----
// Channel   Handshake               Payload
// s_        s_valid / s_ready       s_data    (ctia_pkg::in_t), detection or end of frame
// m_        m_valid / m_ready       m_data    (ctia_pkg::out_t), one item per detection
// cfg_      cfg_valid / cfg_ready   cfg_index, cfg_data, register writes
//
// A detection is latched, then the entry memory is read once per table entry, the compare
// pipeline drains and the result is committed; no new item is taken until that commit.
// An end-of-frame item is taken while idle, drops unhit entries and yields no result.
// Reset (aresetn, synchronous) empties the table and zeroes both IDs; no clearing pass.
// A result held in the output register stalls only the commit of the following detection.
module centroid_track_id_assigner #(
    parameter int TABLE_ENTRIES = ctia_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = ctia_pkg::ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ctia_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ctia_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctia_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ctia_pkg::cmd_t    cmd;
    ctia_pkg::status_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ctia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_func (s_data.func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ctia_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
